// ----- hdl/msjd_pkg.sv -----
// Shared types and constants for the multi-server job dispatcher.
// No dependencies; used by msjd_cell and multi_server_job_dispatcher_top.
package msjd_pkg;

	// Flags carried by the search token from cell to cell
	typedef struct packed {
		logic valid;     // token present at this cell boundary
		logic found;     // an idle server has been chosen
		logic have_min;  // a busy candidate is held in min_end
	} msjd_flags_t;

	// Configuration register indexes
	localparam logic REG_SERVER_COUNT = 1'b0;
	localparam logic REG_SERVICE_CAP  = 1'b1;

	// Configuration reset values
	localparam logic [4:0] SERVER_COUNT_RESET = 5'd1;
	localparam logic [7:0] SERVICE_CAP_RESET  = 8'd60;

	// Saturation limits of the counters
	localparam logic [15:0] CNT_MAX = 16'hFFFF;
	localparam logic [31:0] SUM_MAX = 32'hFFFF_FFFF;

endpackage

// ----- hdl/msjd_cell.sv -----
// One server cell of the dispatcher chain: holds the server's end time, busy
// mark and served count, and refines the search token as it passes by.
// Depends on msjd_pkg.
module msjd_cell #(
	parameter int MAX_SERVERS = 16,
	parameter int TIME_BITS   = 17,
	parameter int INDEX       = 0
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// search token in from the left neighbor
	input  msjd_pkg::msjd_flags_t                 flags_in,
	input  logic [TIME_BITS-1:0]                  min_in,
	input  logic [((MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1)-1:0] pick_in,
	input  logic [15:0]                           served_in,
	// search token out to the right neighbor
	output msjd_pkg::msjd_flags_t                 flags_out,
	output logic [TIME_BITS-1:0]                  min_out,
	output logic [((MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1)-1:0] pick_out,
	output logic [15:0]                           served_out,
	// job context and commit broadcast
	input  logic [15:0]                           arrival,
	input  logic [$clog2(MAX_SERVERS+1)-1:0]      count,
	input  logic                                  upd_we,
	input  logic [((MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1)-1:0] upd_pick,
	input  logic [TIME_BITS-1:0]                  upd_end
);

	localparam int IDX_W  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int CALC_W = ((TIME_BITS > 16) ? TIME_BITS : 16) + 1;
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic [TIME_BITS-1:0]  end_q;
	logic                  busy_q;
	logic [15:0]           served_q;

	msjd_pkg::msjd_flags_t flags_q;
	logic [TIME_BITS-1:0]  min_q;
	logic [IDX_W-1:0]      pick_q;
	logic [15:0]           cand_q;

	msjd_pkg::msjd_flags_t flags_d;
	logic [TIME_BITS-1:0]  min_d;
	logic [IDX_W-1:0]      pick_d;
	logic [15:0]           cand_d;
	logic                  in_use;
	logic                  is_free;
	logic                  is_earlier;

	assign in_use     = 32'(count) > INDEX;
	assign is_free    = !busy_q || (CALC_W'(end_q) <= CALC_W'(arrival));
	assign is_earlier = !flags_in.have_min || (end_q < min_in);

	always_comb begin
		flags_d = flags_in;
		min_d   = min_in;
		pick_d  = pick_in;
		cand_d  = served_in;
		if (in_use && !flags_in.found) begin
			if (is_free) begin
				flags_d.found = 1'b1;
				pick_d        = MY_IDX;
				cand_d        = served_q;
			end else if (is_earlier) begin
				flags_d.have_min = 1'b1;
				min_d            = end_q;
				pick_d           = MY_IDX;
				cand_d           = served_q;
			end
		end
	end

	// Advance the token; hold its payload once it has passed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else begin
			flags_q.valid <= flags_in.valid;
			if (flags_in.valid) begin
				flags_q.found    <= flags_d.found;
				flags_q.have_min <= flags_d.have_min;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (flags_in.valid) begin
			min_q  <= min_d;
			pick_q <= pick_d;
			cand_q <= cand_d;
		end
	end

	// Server state, written by the commit broadcast
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_q    <= '0;
			busy_q   <= 1'b0;
			served_q <= '0;
		end else if (upd_we && (upd_pick == MY_IDX)) begin
			end_q  <= upd_end;
			busy_q <= 1'b1;
			if (served_q != msjd_pkg::CNT_MAX) begin
				served_q <= served_q + 16'd1;
			end
		end
	end

	assign flags_out  = flags_q;
	assign min_out    = min_q;
	assign pick_out   = pick_q;
	assign served_out = cand_q;

endmodule

// ----- hdl/multi_server_job_dispatcher_top.sv -----
// Top level of the multi-server job dispatcher: config registers, job
// sequencer, statistics and output register around a chain of msjd_cell.
// Depends on msjd_pkg and msjd_cell.
//
//   channel  | direction | contents
//   ---------+-----------+-------------------------------------------------
//   s_*      | in        | one job: arrival, service_time
//   m_*      | out       | one result per job: server choice, timing, stats
//   cfg_*    | in        | register writes: server_count, service_cap
//
// From its transaction on s_* to its result, a job passes through tok_q, which
// injects the search token, each server cell as the token walks the chain, the
// scan state that sees it leave the last cell, and the commit state. The next job
// is taken the cycle after the commit, and none while one is in flight. A stall
// on m_* holds the commit until the output register is free. Reset clears server
// state, statistics and config registers (server_count 1, service_cap 60).
module multi_server_job_dispatcher_top #(
	parameter int MAX_SERVERS = 16,
	parameter int TIME_BITS   = 17
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// s_tdata, low bit up: arrival[15:0], service_time[15:0]
	input  logic [31:0]         s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// m_tdata, low bit up: server_index[3:0], wait_time, start, finish
	// (TIME_BITS each), server_jobs[15:0], max_wait (TIME_BITS),
	// total_wait[31:0], latest_end (TIME_BITS), jobs_seen[15:0], zero fill
	output logic [((68 + 5*TIME_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_data
);

	localparam int IDX_W    = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int CNT_W    = $clog2(MAX_SERVERS + 1);
	localparam int CALC_W   = ((TIME_BITS > 16) ? TIME_BITS : 16) + 1;
	localparam int OUT_BITS = 68 + 5 * TIME_BITS;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;

	// ---------------- configuration registers ----------------
	logic [4:0]       server_count_q;
	logic [7:0]       service_cap_q;
	logic [CNT_W-1:0] count_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_count_q <= msjd_pkg::SERVER_COUNT_RESET;
			service_cap_q  <= msjd_pkg::SERVICE_CAP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				msjd_pkg::REG_SERVER_COUNT: server_count_q <= cfg_data[4:0];
				msjd_pkg::REG_SERVICE_CAP:  service_cap_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Zero servers acts as one; counts beyond the built maximum are clipped
	always_comb begin
		if (server_count_q == 5'd0) begin
			count_eff = CNT_W'(1);
		end else if (32'(server_count_q) > MAX_SERVERS) begin
			count_eff = CNT_W'(MAX_SERVERS);
		end else begin
			count_eff = CNT_W'(server_count_q);
		end
	end

	// ---------------- job intake ----------------
	logic [1:0]  state_q;
	logic        tok_q;
	logic [15:0] arr_q;
	logic [7:0]  svc_q;
	logic        s_accept;
	logic [15:0] svc_in;

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign svc_in   = s_tdata[31:16];

	// Latch the job and clamp its service time to the cap
	always_ff @(posedge clk) begin
		if (s_accept) begin
			arr_q <= s_tdata[15:0];
			svc_q <= (svc_in > 16'(service_cap_q)) ? service_cap_q : svc_in[7:0];
		end
	end

	// ---------------- cell chain ----------------
	msjd_pkg::msjd_flags_t flags_c  [0:MAX_SERVERS];
	logic [TIME_BITS-1:0]  min_c    [0:MAX_SERVERS];
	logic [IDX_W-1:0]      pick_c   [0:MAX_SERVERS];
	logic [15:0]           served_c [0:MAX_SERVERS];

	logic                  upd_we;
	logic [TIME_BITS-1:0]  end_t;

	// Inject an empty token in the cycle after the job transaction
	assign flags_c[0]  = '{valid: tok_q, found: 1'b0, have_min: 1'b0};
	assign min_c[0]    = '0;
	assign pick_c[0]   = '0;
	assign served_c[0] = '0;

	for (genvar g = 0; g < MAX_SERVERS; g++) begin : g_cell
		msjd_cell #(
			.MAX_SERVERS (MAX_SERVERS),
			.TIME_BITS   (TIME_BITS),
			.INDEX       (g)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.flags_in   (flags_c[g]),
			.min_in     (min_c[g]),
			.pick_in    (pick_c[g]),
			.served_in  (served_c[g]),
			.flags_out  (flags_c[g+1]),
			.min_out    (min_c[g+1]),
			.pick_out   (pick_c[g+1]),
			.served_out (served_c[g+1]),
			.arrival    (arr_q),
			.count      (count_eff),
			.upd_we     (upd_we),
			.upd_pick   (pick_c[MAX_SERVERS]),
			.upd_end    (end_t)
		);
	end

	// ---------------- sequencer ----------------
	logic out_free;
	logic m_tvalid_q;

	assign out_free = !m_tvalid_q || m_tready;
	assign upd_we   = (state_q == ST_COMMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tok_q   <= 1'b0;
		end else begin
			tok_q <= s_accept;
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// token has left the last cell: the choice is final
					if (flags_c[MAX_SERVERS].valid) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- commit arithmetic ----------------
	logic                 found;
	logic [TIME_BITS-1:0] min_end;
	logic [TIME_BITS-1:0] arr_sat;
	logic [TIME_BITS-1:0] start_t;
	logic [TIME_BITS-1:0] wait_t;
	logic [TIME_BITS:0]   end_sum;
	logic [15:0]          served_pick;
	logic [15:0]          served_new;

	assign found       = flags_c[MAX_SERVERS].found;
	assign min_end     = min_c[MAX_SERVERS];
	assign served_pick = served_c[MAX_SERVERS];

	// Arrival clipped to the time range (only bites for narrow time words)
	assign arr_sat = (CALC_W'(arr_q) > CALC_W'(TIME_MAX)) ? TIME_MAX
	                                                     : TIME_BITS'(arr_q);
	assign start_t = found ? arr_sat : min_end;
	// A busy pick always ends after the arrival, so the difference is positive
	assign wait_t  = found ? '0 : TIME_BITS'(CALC_W'(min_end) - CALC_W'(arr_q));
	assign end_sum = {1'b0, start_t} + (TIME_BITS+1)'(svc_q);
	assign end_t   = end_sum[TIME_BITS] ? TIME_MAX : end_sum[TIME_BITS-1:0];
	assign served_new = (served_pick == msjd_pkg::CNT_MAX) ? served_pick
	                                                      : served_pick + 16'd1;

	// ---------------- running statistics ----------------
	logic [TIME_BITS-1:0] worst_q;
	logic [31:0]          sum_q;
	logic [TIME_BITS-1:0] latest_q;
	logic [15:0]          jobs_q;
	logic [TIME_BITS-1:0] worst_d;
	logic [31:0]          sum_d;
	logic [32:0]          sum_add;
	logic [TIME_BITS-1:0] latest_d;
	logic [15:0]          jobs_d;

	assign worst_d  = (wait_t > worst_q) ? wait_t : worst_q;
	assign sum_add  = {1'b0, sum_q} + 33'(wait_t);
	assign sum_d    = sum_add[32] ? msjd_pkg::SUM_MAX : sum_add[31:0];
	assign latest_d = (end_t > latest_q) ? end_t : latest_q;
	assign jobs_d   = (jobs_q == msjd_pkg::CNT_MAX) ? jobs_q : jobs_q + 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			worst_q  <= '0;
			sum_q    <= '0;
			latest_q <= '0;
			jobs_q   <= '0;
		end else if (upd_we) begin
			worst_q  <= worst_d;
			sum_q    <= sum_d;
			latest_q <= latest_d;
			jobs_q   <= jobs_d;
		end
	end

	// ---------------- output register ----------------
	logic [3:0]           o_idx_q;
	logic [TIME_BITS-1:0] o_wait_q;
	logic [TIME_BITS-1:0] o_start_q;
	logic [TIME_BITS-1:0] o_end_q;
	logic [15:0]          o_served_q;
	logic [TIME_BITS-1:0] o_worst_q;
	logic [31:0]          o_sum_q;
	logic [TIME_BITS-1:0] o_latest_q;
	logic [15:0]          o_jobs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (upd_we) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Load the result with the statistics as they stand after this job
	always_ff @(posedge clk) begin
		if (upd_we) begin
			o_idx_q    <= 4'(pick_c[MAX_SERVERS]);
			o_wait_q   <= wait_t;
			o_start_q  <= start_t;
			o_end_q    <= end_t;
			o_served_q <= served_new;
			o_worst_q  <= worst_d;
			o_sum_q    <= sum_d;
			o_latest_q <= latest_d;
			o_jobs_q   <= jobs_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'({o_jobs_q, o_latest_q, o_sum_q, o_worst_q, o_served_q,
	                          o_end_q, o_start_q, o_wait_q, o_idx_q});

endmodule
